/* rtl/core/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/csa_pkg.sv */
`timescale 1ns / 1ps

package csa_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_PROF_EN  = 2'd0;
  localparam logic [1:0] REG_BIG_ON   = 2'd1;
  localparam logic [1:0] REG_BIG_THR  = 2'd2;

  // table key
  typedef struct packed {
    logic [9:0]  op;
    logic [15:0] rank;
    logic [63:0] addr;
  } key_t;

  // per-entry statistics as held in the stats memory
  typedef struct packed {
    logic [31:0] calls;
    logic [63:0] tsum;
    logic [63:0] tsq;
    logic [31:0] dmin;
    logic [31:0] dmax;
    logic [63:0] ssum;
    logic [31:0] smin;
    logic [31:0] smax;
    logic [63:0] iosum;
    logic [31:0] iomax;
    logic [31:0] big;
  } stats_t;

  localparam int KEY_W   = $bits(key_t);
  localparam int STATS_W = $bits(stats_t);

  // control sequencer
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_MISS = 6'b000100,
    ST_SRD  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_WB   = 6'b100000
  } state_t;

endpackage

/* rtl/core/csa_ram.sv */
`timescale 1ns / 1ps

module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/callsite_stats_accumulator.sv */
`timescale 1ns / 1ps
// Call-site statistics table.
// Input channel: an event word (key operation/rank/address plus duration,
// sent bytes and io bytes) is taken when start is high and busy is low.
// Config port: cfg_we writes cfg_wdata into register cfg_index at once;
// write only while busy is low.
// Output channel: out_valid is high for one cycle with the entry's
// statistics after the update; the receiver cannot stall, so it must
// take the word in that cycle.
// Timing: the key memory is scanned one entry per cycle over the entries
// in use. A hit goes on through SRD, UPD and WB, a new key through MISS,
// SRD, UPD and WB; with the table full, MISS goes to WB, no entry is
// claimed and the word is all zero with out_table_full. busy drops in the
// cycle after out_valid, and the next event may be taken then.
// While profiling is disabled an event is taken and dropped, no result.
// Reset empties the table (fill count to zero) and restores the register
// defaults; no clearing pass is needed.
`include "assert_macros.svh"

module callsite_stats_accumulator #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  in_operation_id,
  input  logic [15:0] in_process_rank,
  input  logic [63:0] in_callsite_address,
  input  logic [31:0] in_duration_ticks,
  input  logic [31:0] in_sent_bytes,
  input  logic [31:0] in_io_bytes,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_table_full,
  output logic [31:0] out_call_count,
  output logic [63:0] out_time_sum,
  output logic [63:0] out_time_square_sum,
  output logic [31:0] out_shortest_duration,
  output logic [31:0] out_longest_duration,
  output logic [63:0] out_sent_total,
  output logic [31:0] out_sent_smallest,
  output logic [31:0] out_sent_largest,
  output logic [63:0] out_io_total,
  output logic [31:0] out_io_largest,
  output logic [31:0] out_big_message_total
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  csa_pkg::state_t state_r, state_nxt;

  logic        prof_en_r, big_on_r;
  logic [31:0] big_thr_r;

  csa_pkg::key_t key_r;
  logic [31:0]   dur_r, sent_r, io_r;
  logic [63:0]   sq_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic             new_r, new_nxt;
  logic             full_r, full_nxt;

  csa_pkg::stats_t  res_r, res_nxt, base, stat_rdata;
  logic [csa_pkg::KEY_W-1:0]   key_rdata;
  logic [csa_pkg::STATS_W-1:0] stat_rdata_raw;
  logic                        key_we;
  logic                        match;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != csa_pkg::ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prof_en_r <= 1'b1;
      big_on_r  <= 1'b0;
      big_thr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csa_pkg::REG_PROF_EN: prof_en_r <= cfg_wdata[0];
        csa_pkg::REG_BIG_ON:  big_on_r  <= cfg_wdata[0];
        csa_pkg::REG_BIG_THR: big_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // event word capture and duration square
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r  <= '{op: in_operation_id, rank: in_process_rank,
                  addr: in_callsite_address};
      dur_r  <= in_duration_ticks;
      sent_r <= in_sent_bytes;
      io_r   <= in_io_bytes;
    end
    if (state_r == csa_pkg::ST_SCAN) begin
      sq_r <= 64'(dur_r) * 64'(dur_r);
    end
  end

  // key memory, read by the scan, written when a new key is claimed
  csa_ram #(.WIDTH(csa_pkg::KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (key_r),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  // stats memory, read-modify-write of the matched or newly claimed entry
  csa_ram #(.WIDTH(csa_pkg::STATS_W), .DEPTH(TABLE_ENTRIES)) u_stats_ram (
    .clk   (clk),
    .we    ((state_r == csa_pkg::ST_WB) && !full_r),
    .waddr (hit_idx_r),
    .wdata (res_r),
    .raddr (hit_idx_r),
    .rdata (stat_rdata_raw)
  );

  assign stat_rdata = stat_rdata_raw;
  assign match      = (key_rdata == key_r);
  assign key_we     = (state_r == csa_pkg::ST_MISS) && (cnt_r != FULL_CNT);

  // saturating adds
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  // entry update
  always_comb begin
    if (new_r) begin
      base = '0;
      base.dmin = '1;
      base.smin = '1;
    end else begin
      base = stat_rdata;
    end
    res_nxt       = base;
    res_nxt.calls = sat_inc(base.calls);
    res_nxt.tsum  = sat_add(base.tsum, 64'(dur_r));
    res_nxt.tsq   = sat_add(base.tsq, sq_r);
    res_nxt.ssum  = sat_add(base.ssum, 64'(sent_r));
    res_nxt.iosum = sat_add(base.iosum, 64'(io_r));
    if (dur_r < base.dmin) res_nxt.dmin = dur_r;
    if (dur_r > base.dmax) res_nxt.dmax = dur_r;
    if (sent_r < base.smin) res_nxt.smin = sent_r;
    if (sent_r > base.smax) res_nxt.smax = sent_r;
    if (io_r > base.iomax) res_nxt.iomax = io_r;
    if (big_on_r && (sent_r >= big_thr_r)) res_nxt.big = sat_inc(base.big);
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    scan_idx_nxt = scan_idx_r;
    cmp_idx_nxt  = cmp_idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    hit_idx_nxt  = hit_idx_r;
    new_nxt      = new_r;
    full_nxt     = full_r;
    unique case (state_r)
      csa_pkg::ST_IDLE: begin
        if (accept && prof_en_r) begin
          state_nxt    = csa_pkg::ST_SCAN;
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          full_nxt     = 1'b0;
        end
      end
      csa_pkg::ST_SCAN: begin
        if (cmp_vld_r && match) begin
          hit_idx_nxt = cmp_idx_r;
          new_nxt     = 1'b0;
          state_nxt   = csa_pkg::ST_SRD;
        end else if (scan_idx_r < cnt_r) begin
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else begin
          state_nxt = csa_pkg::ST_MISS;
        end
      end
      csa_pkg::ST_MISS: begin
        if (cnt_r == FULL_CNT) begin
          full_nxt  = 1'b1;
          state_nxt = csa_pkg::ST_WB;
        end else begin
          hit_idx_nxt = cnt_r[IDX_W-1:0];
          new_nxt     = 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
          state_nxt   = csa_pkg::ST_SRD;
        end
      end
      csa_pkg::ST_SRD: state_nxt = csa_pkg::ST_UPD;
      csa_pkg::ST_UPD: state_nxt = csa_pkg::ST_WB;
      csa_pkg::ST_WB:  state_nxt = csa_pkg::ST_IDLE;
      default:         state_nxt = csa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= csa_pkg::ST_IDLE;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
      full_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      full_r    <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    new_r      <= new_nxt;
    if (state_r == csa_pkg::ST_UPD) begin
      res_r <= res_nxt;
    end else if (state_r == csa_pkg::ST_MISS) begin
      res_r <= '0;
    end
  end

  // result word
  assign out_valid             = (state_r == csa_pkg::ST_WB);
  assign out_table_full        = full_r;
  assign out_call_count        = res_r.calls;
  assign out_time_sum          = res_r.tsum;
  assign out_time_square_sum   = res_r.tsq;
  assign out_shortest_duration = res_r.dmin;
  assign out_longest_duration  = res_r.dmax;
  assign out_sent_total        = res_r.ssum;
  assign out_sent_smallest     = res_r.smin;
  assign out_sent_largest      = res_r.smax;
  assign out_io_total          = res_r.iosum;
  assign out_io_largest        = res_r.iomax;
  assign out_big_message_total = res_r.big;

  // checks
  `ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= FULL_CNT, "fill count beyond table size")
  `ASSERT_SAME(a_full_only_when_full, out_valid && out_table_full, cnt_r == FULL_CNT,
               "table full reported with free entries")
  `ASSERT_NEXT(a_enabled_goes_busy, accept && prof_en_r, busy, "enabled event not taken")

endmodule

/* tb/sv/tb_callsite_stats_accumulator.sv */
`timescale 1ns / 1ps

module tb_callsite_stats_accumulator;

  localparam int ENTRIES = 256;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = ENTRIES + 20;

  // one result word as predicted
  typedef struct {
    bit              full;
    csa_pkg::stats_t s;
  } stats_word_t;

  // predicts the statistics table and checks each result word in order
  class callsite_table_scoreboard;
    bit              prof_en;
    bit              big_on;
    logic [31:0]     big_thr;
    csa_pkg::key_t   keys[ENTRIES];
    csa_pkg::stats_t rows[ENTRIES];
    int              used;
    stats_word_t     pending[$];
    int              mismatches;
    int              words_checked;
    int              full_words;

    function new();
      prof_en = 1'b1;
      big_on = 1'b0;
      big_thr = '0;
      used = 0;
      mismatches = 0;
      words_checked = 0;
      full_words = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        csa_pkg::REG_PROF_EN: prof_en = val[0];
        csa_pkg::REG_BIG_ON:  big_on = val[0];
        csa_pkg::REG_BIG_THR: big_thr = val;
        default: ;
      endcase
    endfunction

    function logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
      logic [64:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[64] ? '1 : t[63:0];
    endfunction

    function logic [31:0] inc_clip(logic [31:0] a);
      return (a == '1) ? a : a + 32'd1;
    endfunction

    // an accepted event updates the table and queues the word it causes, while profiling is enabled
    function void note_event(csa_pkg::key_t k, logic [31:0] dur, logic [31:0] sent,
                             logic [31:0] io);
      int              idx;
      csa_pkg::stats_t r;
      stats_word_t     w;
      logic [63:0]     sq;
      idx = -1;
      if (!prof_en) return;
      for (int i = 0; i < used; i++) begin
        if (keys[i] == k) begin
          idx = i;
          break;
        end
      end
      // new key: claim the next entry, or report a full table
      if (idx < 0) begin
        if (used >= ENTRIES) begin
          w.full = 1'b1;
          w.s = '0;
          pending.push_back(w);
          return;
        end
        idx = used;
        used++;
        keys[idx] = k;
        r = '0;
        r.dmin = '1;
        r.smin = '1;
        rows[idx] = r;
      end
      r = rows[idx];
      sq = {32'd0, dur} * {32'd0, dur};
      r.calls = inc_clip(r.calls);
      r.tsum = add_clip(r.tsum, {32'd0, dur});
      r.tsq = add_clip(r.tsq, sq);
      if (dur > r.dmax) r.dmax = dur;
      if (dur < r.dmin) r.dmin = dur;
      r.ssum = add_clip(r.ssum, {32'd0, sent});
      r.iosum = add_clip(r.iosum, {32'd0, io});
      if (sent > r.smax) r.smax = sent;
      if (sent < r.smin) r.smin = sent;
      if (io > r.iomax) r.iomax = io;
      if (big_on && sent >= big_thr) r.big = inc_clip(r.big);
      rows[idx] = r;
      w.full = 1'b0;
      w.s = r;
      pending.push_back(w);
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (got_v !== exp_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch %s: expected %h got %h", name, exp_v, got_v);
      end
    endfunction

    function void check_word(bit full, csa_pkg::stats_t got);
      stats_word_t w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result word with none pending");
        return;
      end
      w = pending.pop_front();
      words_checked++;
      if (w.full) full_words++;
      compare_field("table_full", 64'(w.full), 64'(full));
      compare_field("call_count", 64'(w.s.calls), 64'(got.calls));
      compare_field("time_sum", w.s.tsum, got.tsum);
      compare_field("time_square_sum", w.s.tsq, got.tsq);
      compare_field("shortest_duration", 64'(w.s.dmin), 64'(got.dmin));
      compare_field("longest_duration", 64'(w.s.dmax), 64'(got.dmax));
      compare_field("sent_total", w.s.ssum, got.ssum);
      compare_field("sent_smallest", 64'(w.s.smin), 64'(got.smin));
      compare_field("sent_largest", 64'(w.s.smax), 64'(got.smax));
      compare_field("io_total", w.s.iosum, got.iosum);
      compare_field("io_largest", 64'(w.s.iomax), 64'(got.iomax));
      compare_field("big_message_total", 64'(w.s.big), 64'(got.big));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [9:0]  in_operation_id;
  logic [15:0] in_process_rank;
  logic [63:0] in_callsite_address;
  logic [31:0] in_duration_ticks;
  logic [31:0] in_sent_bytes;
  logic [31:0] in_io_bytes;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        out_valid;
  logic        out_table_full;
  logic [31:0] out_call_count;
  logic [63:0] out_time_sum;
  logic [63:0] out_time_square_sum;
  logic [31:0] out_shortest_duration;
  logic [31:0] out_longest_duration;
  logic [63:0] out_sent_total;
  logic [31:0] out_sent_smallest;
  logic [31:0] out_sent_largest;
  logic [63:0] out_io_total;
  logic [31:0] out_io_largest;
  logic [31:0] out_big_message_total;

  callsite_table_scoreboard sb;
  csa_pkg::key_t key_pool[$];
  int   events_sent;
  int   stall_cycles;

  callsite_stats_accumulator #(.TABLE_ENTRIES(ENTRIES)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation_id(in_operation_id), .in_process_rank(in_process_rank),
    .in_callsite_address(in_callsite_address), .in_duration_ticks(in_duration_ticks),
    .in_sent_bytes(in_sent_bytes), .in_io_bytes(in_io_bytes),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_table_full(out_table_full),
    .out_call_count(out_call_count), .out_time_sum(out_time_sum),
    .out_time_square_sum(out_time_square_sum),
    .out_shortest_duration(out_shortest_duration),
    .out_longest_duration(out_longest_duration), .out_sent_total(out_sent_total),
    .out_sent_smallest(out_sent_smallest), .out_sent_largest(out_sent_largest),
    .out_io_total(out_io_total), .out_io_largest(out_io_largest),
    .out_big_message_total(out_big_message_total)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result monitor
  always @(posedge clk) begin
    csa_pkg::stats_t got;
    if (rst_n && out_valid) begin
      got.calls = out_call_count;
      got.tsum = out_time_sum;
      got.tsq = out_time_square_sum;
      got.dmin = out_shortest_duration;
      got.dmax = out_longest_duration;
      got.ssum = out_sent_total;
      got.smin = out_sent_smallest;
      got.smax = out_sent_largest;
      got.iosum = out_io_total;
      got.iomax = out_io_largest;
      got.big = out_big_message_total;
      sb.check_word(out_table_full, got);
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL callsite_stats_accumulator");
        $finish;
      end
    end
  end

  // one event word, held until taken; called at a rising edge
  task automatic send_event(csa_pkg::key_t k, logic [31:0] dur, logic [31:0] sent,
                            logic [31:0] io);
    start <= 1'b1;
    in_operation_id <= k.op;
    in_process_rank <= k.rank;
    in_callsite_address <= k.addr;
    in_duration_ticks <= dur;
    in_sent_bytes <= sent;
    in_io_bytes <= io;
    do @(posedge clk); while (busy);
    sb.note_event(k, dur, sent, io);
    events_sent++;
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // register write once all words are in and the block is quiet
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    idle_gap(1);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [31:0] pick_amount();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic csa_pkg::key_t pick_key();
    csa_pkg::key_t k;
    if (key_pool.size() != 0 && $urandom_range(0, 99) < 78) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else begin
      k.op = 10'($urandom);
      k.rank = 16'($urandom);
      k.addr = {$urandom, $urandom};
      key_pool.push_back(k);
    end
    return k;
  endfunction

  initial begin
    csa_pkg::key_t k0;
    csa_pkg::key_t k1;
    csa_pkg::key_t k2;
    int   burst;
    sb = new();
    events_sent = 0;
    start = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = csa_pkg::REG_PROF_EN;
    cfg_wdata = '0;
    in_operation_id = '0;
    in_process_rank = '0;
    in_callsite_address = '0;
    in_duration_ticks = '0;
    in_sent_bytes = '0;
    in_io_bytes = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, repeats and square-sum saturation
    k0 = '0;
    k1 = '1;
    k2.op = 10'h2aa;
    k2.rank = 16'h5555;
    k2.addr = 64'ha5a5_5a5a_0f0f_f0f0;
    send_event(k0, '0, '0, '0);
    send_event(k1, '1, '1, '1);
    send_event(k1, '1, '1, '1);
    send_event(k1, 32'd1, 32'd0, 32'd7);
    send_event(k0, 32'd5, 32'd9, '1);
    send_event(k2, 32'h8000_0000, 32'd100, 32'd0);
    write_reg(csa_pkg::REG_BIG_ON, 32'd1);
    send_event(k2, 32'd3, 32'd0, 32'd1);
    send_event(k0, 32'd2, '1, 32'd4);
    write_reg(csa_pkg::REG_BIG_THR, '1);
    send_event(k1, 32'd0, '1, 32'd0);
    send_event(k1, 32'd0, 32'hffff_fffe, 32'd0);
    write_reg(csa_pkg::REG_BIG_THR, 32'd100);
    send_event(k2, 32'd4, 32'd99, 32'd2);
    send_event(k2, 32'd4, 32'd100, 32'd2);
    // out-of-range index leaves every register alone
    write_reg(2'd3, '0);
    send_event(k2, 32'd6, 32'd101, 32'd3);
    // profiling off: events dropped
    write_reg(csa_pkg::REG_PROF_EN, 32'd0);
    send_event(k0, 32'd1, 32'd1, 32'd1);
    send_event(k1, 32'd1, 32'd1, 32'd1);
    write_reg(csa_pkg::REG_PROF_EN, 32'd1);
    send_event(k0, 32'd1, 32'd1, 32'd1);
    key_pool.push_back(k0);
    key_pool.push_back(k1);
    key_pool.push_back(k2);

    // random bursts over a growing key pool; table fills and overflows
    for (int n = 0; n < 1950; ) begin
      if (n % 300 == 299) begin
        write_reg(csa_pkg::REG_BIG_ON, $urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: write_reg(csa_pkg::REG_BIG_THR, '0);
          1: write_reg(csa_pkg::REG_BIG_THR, '1);
          default: write_reg(csa_pkg::REG_BIG_THR, pick_amount());
        endcase
        if ($urandom_range(0, 2) == 0) begin
          write_reg(csa_pkg::REG_PROF_EN, 32'd0);
          repeat ($urandom_range(1, 4)) send_event(pick_key(), pick_amount(),
                                                   pick_amount(), pick_amount());
          write_reg(csa_pkg::REG_PROF_EN, 32'd1);
        end
      end
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        send_event(pick_key(), pick_amount(), pick_amount(), pick_amount());
        n++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    idle_gap(1);

    // drain
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d events sent, %0d result words checked, %0d of them table-full",
             events_sent, sb.words_checked, sb.full_words);
    $display("%0d distinct keys offered, %0d table entries in use",
             key_pool.size(), sb.used);
    if (sb.mismatches == 0) begin
      $display("PASS callsite_stats_accumulator");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAIL callsite_stats_accumulator");
    end
    $finish;
  end

endmodule
